FILE: rtl/core/rdq_pkg.sv
// Shared definitions for the reversible deque core.
// Operation and status codes, field widths and parameter defaults.
// No dependencies.
`default_nettype none

package rdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 80;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_BACK  = 3'd1;
  localparam kind_t KIND_POP_FRONT  = 3'd2;
  localparam kind_t KIND_POP_BACK   = 3'd3;
  localparam kind_t KIND_REVERSE    = 3'd4;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/rdq_ring_mem.sv
// Ring store of the deque: one write port and two registered read ports.
// A read of the slot written in the same cycle returns the new word.
// Depends on rdq_pkg for parameter defaults.
`default_nettype none

module rdq_ring_mem #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr_a,
  input  wire logic [AW-1:0]         raddr_b,
  output logic      [DATA_WIDTH-1:0] rdata_a,
  output logic      [DATA_WIDTH-1:0] rdata_b
);
  import rdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr_a)) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= mem[raddr_a];
      end
      if (we && (waddr == raddr_b)) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= mem[raddr_b];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/reversible_deque_core.sv
// Top level of the reversible deque: pointer control, result stage and output register.
// Depends on rdq_pkg and rdq_ring_mem.
// The result word is registered in the read ports and the result stage, then in the output register.
// Throughput: one word per cycle while the output is taken; set by the two read ports.
// Reset clears the head pointer, the entry count, the direction flag and all valid flags.
// The ring store is not cleared; only written slots are ever shown.
`default_nettype none

module reversible_deque_core #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // value[31:0]
  input  wire logic [rdq_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind[2:0], zeros above
  input  wire logic [rdq_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // front_value[31:0], back_value[63:32], count[70:64], empty_res[71], status[73:72]
  output logic      [rdq_pkg::M_TDATA_W-1:0]  m_tdata
);
  import rdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;
  status_t       status_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;

  logic [AW:0] push_sum, tail_sum;
  logic        s_accept;
  kind_t       kind;

  logic          s1_valid;
  logic [CW-1:0] s1_count;
  logic          s1_rev;
  status_t       s1_status;
  logic          s1_advance;

  logic [VALUE_W-1:0] front_w, back_w;

  assign kind       = s_tuser[KIND_W-1:0];
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign s_accept   = s_tvalid && s_tready;
  assign wdata      = DATA_WIDTH'(s_tdata[VALUE_W-1:0]);
  assign push_sum   = {1'b0, head} + (AW+1)'(count);

  always_comb begin
    head_next   = head;
    count_next  = count;
    rev_next    = rev;
    status_next = STATUS_DONE;
    we          = 1'b0;
    waddr       = head;
    unique case (kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (count == DEPTH_C) begin
          status_next = STATUS_FULL;
        end else begin
          we         = s_accept;
          count_next = count + CW'(1);
          if ((kind == KIND_PUSH_FRONT) != rev) begin
            head_next = (head == '0) ? LAST_SLOT : head - AW'(1);
            waddr     = head_next;
          end else begin
            waddr = (push_sum >= DEPTH_S) ? AW'(push_sum - DEPTH_S) : AW'(push_sum);
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK, KIND_REVERSE: begin
        if (count == '0) begin
          status_next = STATUS_EMPTY;
        end else if (kind == KIND_REVERSE) begin
          rev_next = !rev;
        end else begin
          count_next = count - CW'(1);
          if ((kind == KIND_POP_FRONT) != rev) begin
            head_next = (head == LAST_SLOT) ? '0 : head + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign tail_sum = {1'b0, head_next} + (AW+1)'(count_next) - (AW+1)'(1);
  assign raddr_a  = head_next;
  assign raddr_b  = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

  rdq_ring_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ring_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (s_accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rev      <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        head  <= head_next;
        count <= count_next;
        rev   <= rev_next;
      end
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_count  <= count_next;
      s1_rev    <= rev_next;
      s1_status <= status_next;
    end
  end

  always_comb begin
    front_w = '0;
    back_w  = '0;
    if (s1_count != '0) begin
      front_w = s1_rev ? VALUE_W'(rdata_b) : VALUE_W'(rdata_a);
      back_w  = s1_rev ? VALUE_W'(rdata_a) : VALUE_W'(rdata_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= {6'd0, s1_status, (s1_count == '0), COUNT_W'(s1_count), back_w, front_w};
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    (count <= DEPTH_C) && (head <= LAST_SLOT))
    else $error("deque count or head pointer out of range");

  a_push_grows : assert property (@(posedge clk) disable iff (rst)
    (s_accept && (status_next == STATUS_DONE)
      && ((kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK)))
      |=> (count == $past(count) + CW'(1)))
    else $error("successful push did not grow the count");

  a_reject_holds : assert property (@(posedge clk) disable iff (rst)
    (s_accept && (status_next != STATUS_DONE))
      |=> ((count == $past(count)) && (head == $past(head)) && (rev == $past(rev))))
    else $error("rejected operation changed the deque");

  a_stage_hold : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> !s_tready)
    else $error("new word accepted over a pending result");

  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_valid))
    else $error("output became valid without a pending result");

endmodule

`default_nettype wire
